// File: rtl/pca_pkg.sv
// ============================================================================
// pca_pkg - shared constants for the polar complex arithmetic unit
// Operation codes, angle scaling constants and the CORDIC arc table.
// ============================================================================
package pca_pkg;

  // operation codes carried on req_type
  localparam logic [2:0] OP_ADD_POLAR = 3'd0;
  localparam logic [2:0] OP_ADD_INT   = 3'd1;
  localparam logic [2:0] OP_MUL_POLAR = 3'd2;
  localparam logic [2:0] OP_SCALE_INT = 3'd3;
  localparam logic [2:0] OP_DOT       = 3'd4;
  localparam logic [2:0] OP_QUADRANT  = 3'd5;
  localparam logic [2:0] OP_MAX       = 3'd6;

  // angle grid: 1/128 degree
  localparam logic [15:0] FULL_TURN    = 16'd46080;
  localparam logic [15:0] HALF_TURN    = 16'd23040;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;

  // binary angle = a * 2^22 / 45 = a * TURN_BASE + floor(a * 34 / 45)
  localparam logic [31:0] TURN_BASE   = 32'd93206;
  localparam logic [21:0] DEG_RECIP   = 22'd2982616;  // floor(2^27 / 45)
  localparam int          DEG_SHIFT   = 27;

  localparam int          GUARD_BITS  = 8;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [23:0] RADIUS_MAX  = 24'hFFFFFF;
  localparam logic [63:0] DOT_POS_MAX = 64'h7FFF_FFFF_FFFF;
  localparam logic [63:0] DOT_NEG_MAG = 64'h8000_0000_0000;

  localparam int          MAX_STAGES  = 24;

  // atan(2^-i) on a 2^32 full-turn binary angle
  localparam logic [31:0] ARC_TABLE [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// File: rtl/polar_complex_alu_unit.sv
// ============================================================================
// polar_complex_alu_unit - pipelined arithmetic on polar complex numbers
// Add, multiply, scale, dot product, quadrant and max on Q16.8 radii and
// 1/128-degree angles, with CORDIC rotation and vectoring pipelines.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in_     | input     | in_valid / in_ready    | req_type, operands, integer
//  out_    | output    | out_valid / out_ready  | radius, angle, dot, quadrant,
//          |           |                        | saturation flag
//
//  One transaction enters per cycle while in_ready is high. The pipeline is
//  made of the rotation pipeline, the vectoring pipeline and seven
//  arithmetic stages around them.
//  rst_n (synchronous, active low) clears only the per-stage valid bits.
//  The whole pipeline advances together; when the output holds a transaction
//  that is not taken, every stage holds and in_ready drops, so nothing is
//  lost or repeated. Empty slots are not squeezed out.
//
module polar_complex_alu_unit #(
  parameter int CORDIC_STAGES    = 16,
  parameter int RADIUS_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [23:0]        in_a_radius,
  input  logic [15:0]        in_a_angle,
  input  logic [23:0]        in_b_radius,
  input  logic [15:0]        in_b_angle,
  input  logic signed [15:0] in_int_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_res_radius,
  output logic [15:0]        out_res_angle,
  output logic signed [47:0] out_res_dot,
  output logic [2:0]         out_res_quadrant,
  output logic               out_res_saturated
);

  localparam int N  = CORDIC_STAGES;
  localparam int F  = RADIUS_FRAC_BITS;
  localparam int G  = pca_pkg::GUARD_BITS;
  // coordinate width: room for the integer offset plus two CORDIC gains
  localparam int XW  = (F + 27 > 36) ? F + 27 : 36;
  localparam int GHW = XW + 9;

  // stage positions
  localparam int S_IN  = 0;
  localparam int S_MUL = 1;
  localparam int S_PRE = 2;
  localparam int S_ROT = 3;
  localparam int S_SUM = 3 + N;
  localparam int S_VIN = 4 + N;
  localparam int S_VEC = 5 + N;
  localparam int S_PST = 5 + 2 * N;
  localparam int S_OUT = 6 + 2 * N;
  localparam int L     = 7 + 2 * N;

  localparam logic signed [XW-1:0] C_MAX = XW'(32768);
  localparam logic signed [XW-1:0] C_MIN = -C_MAX;

  typedef struct packed {
    logic [2:0]            op;
    logic [23:0]           ar;
    logic [23:0]           br;
    logic [15:0]           aa;
    logic [15:0]           ba;
    logic [15:0]           ad;     // angle for the first rotator
    logic signed [15:0]    n;
    logic [15:0]           nmag;
    logic [20:0]           t1;
    logic [20:0]           t2;
    logic [42:0]           q1p;
    logic [42:0]           q2p;
    logic [31:0]           base1;
    logic [31:0]           base2;
    logic [53:0]           pa_g;
    logic [53:0]           pb_g;
    logic [47:0]           pab;
    logic [39:0]           pan;
    logic signed [XW-1:0]  x1;
    logic signed [XW-1:0]  y1;
    logic signed [33:0]    z1;
    logic signed [XW-1:0]  x2;
    logic signed [XW-1:0]  y2;
    logic signed [33:0]    z2;
    logic signed [XW-1:0]  xv;
    logic signed [XW-1:0]  yv;
    logic [31:0]           zv;
    logic                  zf;
    logic                  cneg;
    logic [15:0]           uc;
    logic [GHW-1:0]        gh;
    logic [49:0]           gl;
    logic [39:0]           dh;
    logic [39:0]           dl;
    logic [47:0]           ap;
    logic [23:0]           rr;
    logic [15:0]           ra;
    logic signed [47:0]    dotv;
    logic [2:0]            quad;
    logic                  sat;
  } ctx_t;

  ctx_t st_r   [L];
  ctx_t st_nxt [L];
  logic vld_r  [L];
  logic adv;

  assign adv      = !vld_r[L-1] || out_ready;
  assign in_ready = adv;

  // binary angle from a*34 product, its reciprocal estimate and a*TURN_BASE
  function automatic logic [31:0] bin_angle(input logic [20:0] t,
                                            input logic [42:0] qp,
                                            input logic [31:0] base);
    logic [15:0] q;
    logic [20:0] r;
    q = qp[42:pca_pkg::DEG_SHIFT];
    r = t - 21'(q) * 21'd45;
    if (r >= 21'd45) begin
      q = q + 16'd1;
    end
    return base + 32'(q);
  endfunction

  // ---- stage: input capture, angle reduction ------------------------------
  always_comb begin
    ctx_t c;
    c = '0;
    c.op = in_req_type;
    c.ar = in_a_radius;
    c.br = in_b_radius;
    c.aa = (in_a_angle >= pca_pkg::FULL_TURN) ? in_a_angle - pca_pkg::FULL_TURN
                                              : in_a_angle;
    c.ba = (in_b_angle >= pca_pkg::FULL_TURN) ? in_b_angle - pca_pkg::FULL_TURN
                                              : in_b_angle;
    if (c.op == pca_pkg::OP_DOT) begin
      c.ad = (c.aa >= c.ba) ? c.aa - c.ba
                            : 16'(17'(c.aa) + 17'(pca_pkg::FULL_TURN) - 17'(c.ba));
    end else begin
      c.ad = c.aa;
    end
    c.n    = in_int_operand;
    c.nmag = in_int_operand[15] ? 16'(~in_int_operand) + 16'd1 : 16'(in_int_operand);
    st_nxt[S_IN] = c;
  end

  // ---- stage: multipliers ---------------------------------------------------
  always_comb begin
    ctx_t c;
    c       = st_r[S_IN];
    c.t1    = 21'(c.ad) * 21'd34;
    c.t2    = 21'(c.ba) * 21'd34;
    c.q1p   = 43'(c.t1) * 43'(pca_pkg::DEG_RECIP);
    c.q2p   = 43'(c.t2) * 43'(pca_pkg::DEG_RECIP);
    c.base1 = 32'(c.ad) * pca_pkg::TURN_BASE;
    c.base2 = 32'(c.ba) * pca_pkg::TURN_BASE;
    c.pa_g  = 54'(c.ar) * 54'(pca_pkg::GAIN_Q30);
    c.pb_g  = 54'(c.br) * 54'(pca_pkg::GAIN_Q30);
    c.pab   = 48'(c.ar) * 48'(c.br);
    c.pan   = 40'(c.ar) * 40'(c.nmag);
    st_nxt[S_MUL] = c;
  end

  // ---- stage: binary angles, prescale, quadrant fold -----------------------
  always_comb begin
    ctx_t        c;
    logic [31:0] th1;
    logic [31:0] th2;
    logic [31:0] mag1;
    logic [31:0] mag2;
    c    = st_r[S_MUL];
    th1  = bin_angle(c.t1, c.q1p, c.base1);
    th2  = bin_angle(c.t2, c.q2p, c.base2);
    mag1 = (c.op == pca_pkg::OP_DOT) ? 32'(pca_pkg::GAIN_Q30) : c.pa_g[53:22];
    mag2 = c.pb_g[53:22];
    c.x1 = $signed({{(XW-32){1'b0}}, mag1});
    c.x2 = $signed({{(XW-32){1'b0}}, mag2});
    c.y1 = '0;
    c.y2 = '0;
    if (th1[31:30] == 2'b01 || th1[31:30] == 2'b10) begin
      c.x1 = -c.x1;
      th1  = th1 - 32'h8000_0000;
    end
    if (th2[31:30] == 2'b01 || th2[31:30] == 2'b10) begin
      c.x2 = -c.x2;
      th2  = th2 - 32'h8000_0000;
    end
    c.z1 = $signed({{2{th1[31]}}, th1});
    c.z2 = $signed({{2{th2[31]}}, th2});
    st_nxt[S_PRE] = c;
  end

  // ---- rotation pipeline, both operands side by side ------------------------
  for (genvar gi = 0; gi < N; gi++) begin : g_rot
    always_comb begin
      ctx_t                 c;
      logic signed [XW-1:0] dx1, dy1, dx2, dy2;
      logic signed [33:0]   arc;
      c   = st_r[S_ROT + gi - 1];
      arc = $signed({2'b00, pca_pkg::ARC_TABLE[gi]});
      dx1 = c.y1 >>> gi;
      dy1 = c.x1 >>> gi;
      dx2 = c.y2 >>> gi;
      dy2 = c.x2 >>> gi;
      if (!c.z1[33]) begin
        c.x1 = c.x1 - dx1; c.y1 = c.y1 + dy1; c.z1 = c.z1 - arc;
      end else begin
        c.x1 = c.x1 + dx1; c.y1 = c.y1 - dy1; c.z1 = c.z1 + arc;
      end
      if (!c.z2[33]) begin
        c.x2 = c.x2 - dx2; c.y2 = c.y2 + dy2; c.z2 = c.z2 - arc;
      end else begin
        c.x2 = c.x2 + dx2; c.y2 = c.y2 - dy2; c.z2 = c.z2 + arc;
      end
      st_nxt[S_ROT + gi] = c;
    end
  end

  // ---- stage: rectangular sum, cosine for the dot product -------------------
  always_comb begin
    ctx_t                 c;
    logic signed [XW-1:0] addx;
    logic signed [XW-1:0] addy;
    logic signed [XW-1:0] ct;
    c    = st_r[S_SUM - 1];
    addx = '0;
    addy = '0;
    if (c.op == pca_pkg::OP_ADD_POLAR) begin
      addx = c.x2;
      addy = c.y2;
    end else if (c.op == pca_pkg::OP_ADD_INT) begin
      addx = $signed({{(XW-16){c.n[15]}}, c.n}) <<< (F + G);
    end
    c.xv = c.x1 + addx;
    c.yv = c.y1 + addy;
    ct   = (c.x1 + XW'(16384)) >>> 15;
    if (ct > C_MAX) begin
      c.cneg = 1'b0;
      c.uc   = 16'h8000;
    end else if (ct < C_MIN) begin
      c.cneg = 1'b1;
      c.uc   = 16'h8000;
    end else begin
      c.cneg = ct[XW-1];
      c.uc   = ct[XW-1] ? 16'(-ct) : 16'(ct);
    end
    st_nxt[S_SUM] = c;
  end

  // ---- stage: vectoring set-up ---------------------------------------------
  always_comb begin
    ctx_t c;
    c    = st_r[S_VIN - 1];
    c.zf = (c.xv == '0) && (c.yv == '0);
    if (c.xv[XW-1]) begin
      c.xv = -c.xv;
      c.yv = -c.yv;
      c.zv = 32'h8000_0000;
    end else begin
      c.zv = '0;
    end
    st_nxt[S_VIN] = c;
  end

  // ---- vectoring pipeline ----------------------------------------------------
  for (genvar gv = 0; gv < N; gv++) begin : g_vec
    always_comb begin
      ctx_t                 c;
      logic signed [XW-1:0] dx, dy;
      c  = st_r[S_VEC + gv - 1];
      dx = c.yv >>> gv;
      dy = c.xv >>> gv;
      if (!c.yv[XW-1]) begin
        c.xv = c.xv + dx; c.yv = c.yv - dy; c.zv = c.zv + pca_pkg::ARC_TABLE[gv];
      end else begin
        c.xv = c.xv - dx; c.yv = c.yv + dy; c.zv = c.zv - pca_pkg::ARC_TABLE[gv];
      end
      st_nxt[S_VEC + gv] = c;
    end
  end

  // ---- stage: gain, dot and angle products ---------------------------------
  always_comb begin
    ctx_t          c;
    logic [XW-2:0] xc;
    c    = st_r[S_PST - 1];
    xc   = c.xv[XW-1] ? '0 : c.xv[XW-2:0];
    c.gh = GHW'(xc[XW-2:20]) * GHW'(pca_pkg::GAIN_Q30);
    c.gl = 50'(xc[19:0]) * 50'(pca_pkg::GAIN_Q30);
    c.dl = 40'(c.pab[23:0]) * 40'(c.uc);
    c.dh = 40'(c.pab[47:24]) * 40'(c.uc);
    c.ap = 48'(c.zv) * 48'(pca_pkg::FULL_TURN);
    st_nxt[S_PST] = c;
  end

  // ---- stage: rounding, saturation, result select -------------------------
  always_comb begin
    ctx_t           c;
    logic [50:0]    gt;
    logic [GHW-1:0] gsum;
    logic [GHW-1:0] m;
    logic [16:0]    ang;
    logic [63:0]    dp;
    logic [63:0]    dm;
    logic [47:0]    pr;
    logic [16:0]    asum;
    c    = st_r[S_OUT - 1];
    gt   = (51'(c.gh[9:0]) << 20) + 51'(c.gl);
    gsum = (c.gh >> 10) + GHW'(gt >> 30);
    m    = (gsum + GHW'(1 << (G - 1))) >> G;
    ang  = 17'((c.ap + 48'h8000_0000) >> 32);
    dp   = (64'(c.dh) << 24) + 64'(c.dl);
    dm   = (dp + 64'd16384) >> 15;
    pr   = (c.pab + 48'(1 << (F - 1))) >> F;
    asum = '0;
    c.rr   = '0;
    c.ra   = '0;
    c.dotv = '0;
    c.quad = '0;
    c.sat  = 1'b0;
    unique case (c.op)
      pca_pkg::OP_ADD_POLAR, pca_pkg::OP_ADD_INT: begin
        if (!c.zf) begin
          if (m > GHW'(pca_pkg::RADIUS_MAX)) begin
            c.rr  = pca_pkg::RADIUS_MAX;
            c.sat = 1'b1;
          end else begin
            c.rr = m[23:0];
          end
          c.ra = (ang >= 17'(pca_pkg::FULL_TURN)) ? '0 : ang[15:0];
        end
      end
      pca_pkg::OP_MUL_POLAR: begin
        if (pr > 48'(pca_pkg::RADIUS_MAX)) begin
          c.rr  = pca_pkg::RADIUS_MAX;
          c.sat = 1'b1;
        end else begin
          c.rr = pr[23:0];
        end
        asum = 17'(c.aa) + 17'(c.ba);
        c.ra = (asum >= 17'(pca_pkg::FULL_TURN))
               ? 16'(asum - 17'(pca_pkg::FULL_TURN)) : asum[15:0];
      end
      pca_pkg::OP_SCALE_INT: begin
        if (c.pan > 40'(pca_pkg::RADIUS_MAX)) begin
          c.rr  = pca_pkg::RADIUS_MAX;
          c.sat = 1'b1;
        end else begin
          c.rr = c.pan[23:0];
        end
        asum = 17'(c.aa) + (c.n[15] ? 17'(pca_pkg::HALF_TURN) : 17'd0);
        c.ra = (asum >= 17'(pca_pkg::FULL_TURN))
               ? 16'(asum - 17'(pca_pkg::FULL_TURN)) : asum[15:0];
      end
      pca_pkg::OP_DOT: begin
        if (!c.cneg) begin
          if (dm > pca_pkg::DOT_POS_MAX) begin
            dm    = pca_pkg::DOT_POS_MAX;
            c.sat = 1'b1;
          end
          c.dotv = $signed(dm[47:0]);
        end else begin
          if (dm > pca_pkg::DOT_NEG_MAG) begin
            dm    = pca_pkg::DOT_NEG_MAG;
            c.sat = 1'b1;
          end
          c.dotv = -$signed(dm[47:0]);
        end
      end
      pca_pkg::OP_QUADRANT: begin
        if (c.ar == '0 || c.aa < pca_pkg::QUARTER_TURN) begin
          c.quad = 3'd1;
        end else if (c.aa < pca_pkg::HALF_TURN) begin
          c.quad = 3'd2;
        end else if (c.aa < pca_pkg::HALF_TURN + pca_pkg::QUARTER_TURN) begin
          c.quad = 3'd3;
        end else begin
          c.quad = 3'd4;
        end
      end
      pca_pkg::OP_MAX: begin
        if (c.ar >= c.br) begin
          c.rr = c.ar;
          c.ra = c.aa;
        end else begin
          c.rr = c.br;
          c.ra = c.ba;
        end
      end
      default: begin
      end
    endcase
    st_nxt[S_OUT] = c;
  end

  // ---- pipeline registers ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < L; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign out_valid         = vld_r[L-1];
  assign out_res_radius    = st_r[L-1].rr;
  assign out_res_angle     = st_r[L-1].ra;
  assign out_res_dot       = st_r[L-1].dotv;
  assign out_res_quadrant  = st_r[L-1].quad;
  assign out_res_saturated = st_r[L-1].sat;

  // ---- assertions ------------------------------------------------------------
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_angle < pca_pkg::FULL_TURN)
    else $error("result angle not reduced");

  a_quad_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && st_r[L-1].op != pca_pkg::OP_QUADRANT |-> out_res_quadrant == 3'd0)
    else $error("quadrant set on other operation");

  a_sat_ops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_saturated |->
      (st_r[L-1].op == pca_pkg::OP_ADD_POLAR || st_r[L-1].op == pca_pkg::OP_ADD_INT ||
       st_r[L-1].op == pca_pkg::OP_MUL_POLAR || st_r[L-1].op == pca_pkg::OP_SCALE_INT ||
       st_r[L-1].op == pca_pkg::OP_DOT))
    else $error("saturation on operation that cannot saturate");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[L-2] && !out_valid |=> out_valid)
    else $error("transaction lost at output stage");

endmodule
